/* rtl/tr2c_pkg.sv */
// shared types and constants of the touch report to contacts block
// no dependencies; every other file imports it
`timescale 1ns / 1ps
`default_nettype none

package tr2c_pkg;

   localparam int RECORD_COUNT = 5;
   localparam int RECORD_W     = 40;
   localparam int REC_IDX_W    = 3;
   localparam int SLOT_ID_W    = 3;
   localparam int COUNT_W      = 3;
   localparam int TIME_W       = 32;
   localparam int STAMP_W      = 16;
   localparam int HALF_TIME_W  = 16;
   localparam int MAGIC_W      = 33;
   localparam int PROD_W       = HALF_TIME_W + MAGIC_W;
   localparam int SUM_W        = TIME_W + MAGIC_W;
   localparam int GEOM_W       = 12;
   localparam int POS_Y_W      = 16;
   localparam int PRESS_W      = 10;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;

   localparam int DEFAULT_SLOT_COUNT = 5;
   localparam int DEFAULT_TIME_UNIT  = 100;

   localparam logic [GEOM_W-1:0]  GEOM_MAX   = 12'd4095;
   localparam logic [PRESS_W-1:0] PRESS_MAX  = 10'd1023;
   localparam logic [11:0]        PRESS_MUL  = 12'd3216;
   localparam logic [20:0]        PRESS_HALF = 21'd512;
   localparam int                 PRESS_SHIFT = 10;
   localparam int                 TOUCH_BIT0  = 3;
   localparam int                 CLICK_BIT   = 0;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_ID = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_Y       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_X     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_Y     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_OFS   = 3'd4;

   localparam logic [7:0]  RESET_EXPECTED_ID = 8'd93;
   localparam logic [15:0] RESET_MAX_Y       = 16'd4095;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_TOUCH  = 2'd1,
      KIND_LIFT   = 2'd2,
      KIND_REJECT = 2'd3
   } entry_kind_type;

   typedef struct packed {
      logic [7:0]  expected_id;
      logic [15:0] max_y;
      logic [15:0] scale_x;
      logic [15:0] scale_y;
      logic [7:0]  press_ofs;
   } cfg_type;

   typedef struct packed {
      logic [7:0]                              report_id;
      logic [7:0]                              touch_flags;
      logic [RECORD_COUNT-1:0][RECORD_W-1:0]   records;
   } report_type;

endpackage

`default_nettype wire

/* rtl/tr2c_req_if.sv */
// report channel: valid, ready and one raw touchpad report
// depends on tr2c_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface tr2c_req_if
   import tr2c_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic [7:0]           report_id;
   logic [7:0]           touch_flags;
   logic [TIME_W-1:0]    irq_time;
   logic [RECORD_W-1:0]  record_0;
   logic [RECORD_W-1:0]  record_1;
   logic [RECORD_W-1:0]  record_2;
   logic [RECORD_W-1:0]  record_3;
   logic [RECORD_W-1:0]  record_4;

   modport source (
      output valid, report_id, touch_flags, irq_time,
             record_0, record_1, record_2, record_3, record_4,
      input  ready
   );
   modport sink (
      input  valid, report_id, touch_flags, irq_time,
             record_0, record_1, record_2, record_3, record_4,
      output ready
   );
endinterface

`default_nettype wire

/* rtl/tr2c_rsp_if.sv */
// contact entry channel: valid, ready and one contact entry
// depends on tr2c_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface tr2c_rsp_if
   import tr2c_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [1:0]            entry_kind;
   logic [SLOT_ID_W-1:0]  slot_id;
   logic [GEOM_W-1:0]     contact_width;
   logic [GEOM_W-1:0]     contact_height;
   logic [GEOM_W-1:0]     pos_x;
   logic [POS_Y_W-1:0]    pos_y;
   logic [PRESS_W-1:0]    contact_pressure;
   logic [COUNT_W-1:0]    entry_count;
   logic                  button_down;
   logic [STAMP_W-1:0]    time_stamp;
   logic                  last_entry;

   modport source (
      output valid, entry_kind, slot_id, contact_width, contact_height, pos_x,
             pos_y, contact_pressure, entry_count, button_down, time_stamp,
             last_entry,
      input  ready
   );
   modport sink (
      input  valid, entry_kind, slot_id, contact_width, contact_height, pos_x,
             pos_y, contact_pressure, entry_count, button_down, time_stamp,
             last_entry,
      output ready
   );
endinterface

`default_nettype wire

/* rtl/touch_report_to_contacts.sv */
// touch report to contacts, top level
// req_if carries one raw touchpad report per item: report id, touch info,
// interrupt time and five packed contact records. rsp_if carries contact
// entries, one per slot that touches or has just lifted, in slot order, with
// last_entry marking the final entry of a report; an empty report gives one
// no-contact entry and a report with the wrong id one rejected entry.
// csr_* writes the five configuration registers, one per cycle when enabled.
// path: an accepted report passes the input register, two time stamp divider
// stages and the slot scanner before its first entry enters the output register;
// a report with n entries (n from 1 to 5) holds the scanner, which forms one
// entry a cycle while the output does not stall, so one entry reports can be
// taken every cycle. The three stage front end (input register, two time stamp
// divider stages) keeps taking reports while the scanner is busy, until full.
// when rsp_if.ready is low the entry waits in the output register and the
// scanner and front end stall behind it; nothing is dropped.
// reset (synchronous) clears the slot active flags, empties all stages and
// loads the register reset values.
// depends on tr2c_pkg, tr2c_req_if, tr2c_rsp_if, tr2c_csr, tr2c_front, tr2c_emit
`timescale 1ns / 1ps
`default_nettype none

module touch_report_to_contacts
   import tr2c_pkg::*;
#(
   parameter int SLOT_COUNT = DEFAULT_SLOT_COUNT,
   parameter int TIME_UNIT  = DEFAULT_TIME_UNIT
) (
   input  logic                   clock,
   input  logic                   reset,
   tr2c_req_if.sink               req_if,
   tr2c_rsp_if.source             rsp_if,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type             cfg;
   report_type          req_report, scan_report;
   logic                scan_valid, scan_ready;
   logic [STAMP_W-1:0]  scan_stamp;

   assign req_report.report_id   = req_if.report_id;
   assign req_report.touch_flags = req_if.touch_flags;
   assign req_report.records     = {req_if.record_4, req_if.record_3, req_if.record_2,
                                    req_if.record_1, req_if.record_0};

   tr2c_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tr2c_front #(
      .TIME_UNIT (TIME_UNIT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_if.valid),
      .in_ready   (req_if.ready),
      .in_report  (req_report),
      .in_time    (req_if.irq_time),
      .out_valid  (scan_valid),
      .out_ready  (scan_ready),
      .out_report (scan_report),
      .out_stamp  (scan_stamp)
   );

   tr2c_emit #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_emit (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .in_valid     (scan_valid),
      .in_ready     (scan_ready),
      .in_report    (scan_report),
      .in_stamp     (scan_stamp),
      .out_valid    (rsp_if.valid),
      .out_ready    (rsp_if.ready),
      .out_kind     (rsp_if.entry_kind),
      .out_slot     (rsp_if.slot_id),
      .out_width    (rsp_if.contact_width),
      .out_height   (rsp_if.contact_height),
      .out_x        (rsp_if.pos_x),
      .out_y        (rsp_if.pos_y),
      .out_pressure (rsp_if.contact_pressure),
      .out_count    (rsp_if.entry_count),
      .out_button   (rsp_if.button_down),
      .out_stamp    (rsp_if.time_stamp),
      .out_last     (rsp_if.last_entry)
   );

endmodule

`default_nettype wire

/* rtl/tr2c_csr.sv */
// configuration registers written through the plain write port
// depends on tr2c_pkg
`timescale 1ns / 1ps
`default_nettype none

module tr2c_csr
   import tr2c_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_EXPECTED_ID: cfg_in.expected_id = csr_wdata[7:0];
            CSR_MAX_Y:       cfg_in.max_y       = csr_wdata;
            CSR_SCALE_X:     cfg_in.scale_x     = csr_wdata;
            CSR_SCALE_Y:     cfg_in.scale_y     = csr_wdata;
            CSR_PRESS_OFS:   cfg_in.press_ofs   = csr_wdata[7:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_id <= RESET_EXPECTED_ID;
         cfg_ff.max_y       <= RESET_MAX_Y;
         cfg_ff.scale_x     <= '0;
         cfg_ff.scale_y     <= '0;
         cfg_ff.press_ofs   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* rtl/tr2c_front.sv */
// input register and time stamp pipeline: irq_time / TIME_UNIT by reciprocal
// multiply over two stages; depends on tr2c_pkg
`timescale 1ns / 1ps
`default_nettype none

module tr2c_front
   import tr2c_pkg::*;
#(
   parameter int TIME_UNIT = DEFAULT_TIME_UNIT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  report_type          in_report,
   input  logic [TIME_W-1:0]   in_time,
   output logic                out_valid,
   input  logic                out_ready,
   output report_type          out_report,
   output logic [STAMP_W-1:0]  out_stamp
);

   localparam int TsShift = TIME_W + $clog2(TIME_UNIT);
   localparam logic [63:0] TsMagicWide =
      ((64'd1 << TsShift) + 64'(TIME_UNIT) - 64'd1) / 64'(TIME_UNIT);
   localparam logic [MAGIC_W-1:0] TsMagic = TsMagicWide[MAGIC_W-1:0];

   logic                     s1_valid_ff, s1_valid_in;
   logic                     s2_valid_ff, s2_valid_in;
   logic                     s3_valid_ff, s3_valid_in;
   logic                     s1_ready, s2_ready, s3_ready;
   report_type               rpt1_ff, rpt2_ff, rpt3_ff;
   logic [TIME_W-1:0]        time1_ff;
   logic [PROD_W-1:0]        lo_ff, lo_in, hi_ff, hi_in;
   logic [SUM_W-1:0]         quot_sum;
   logic [STAMP_W-1:0]       stamp3_ff, stamp3_in;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   // partial products of the time and the reciprocal, one per half word
   assign lo_in = PROD_W'(time1_ff[HALF_TIME_W-1:0]) * PROD_W'(TsMagic);
   assign hi_in = PROD_W'(time1_ff[TIME_W-1:HALF_TIME_W]) * PROD_W'(TsMagic);

   assign quot_sum  = SUM_W'(lo_ff) + (SUM_W'(hi_ff) << HALF_TIME_W);
   assign stamp3_in = quot_sum[TsShift +: STAMP_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         rpt1_ff  <= in_report;
         time1_ff <= in_time;
      end
      if (s2_ready) begin
         rpt2_ff <= rpt1_ff;
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
      end
      if (s3_ready) begin
         rpt3_ff   <= rpt2_ff;
         stamp3_ff <= stamp3_in;
      end
   end

   assign out_valid  = s3_valid_ff;
   assign out_report = rpt3_ff;
   assign out_stamp  = stamp3_ff;

endmodule

`default_nettype wire

/* rtl/tr2c_emit.sv */
// slot scan: keeps slot active flags, walks the slots that give an entry and
// forms one a cycle into the output register when free; depends on tr2c_pkg
`timescale 1ns / 1ps
`default_nettype none

module tr2c_emit
   import tr2c_pkg::*;
#(
   parameter int SLOT_COUNT = DEFAULT_SLOT_COUNT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  report_type            in_report,
   input  logic [STAMP_W-1:0]    in_stamp,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [1:0]            out_kind,
   output logic [SLOT_ID_W-1:0]  out_slot,
   output logic [GEOM_W-1:0]     out_width,
   output logic [GEOM_W-1:0]     out_height,
   output logic [GEOM_W-1:0]     out_x,
   output logic [POS_Y_W-1:0]    out_y,
   output logic [PRESS_W-1:0]    out_pressure,
   output logic [COUNT_W-1:0]    out_count,
   output logic                  out_button,
   output logic [STAMP_W-1:0]    out_stamp,
   output logic                  out_last
);

   // scan state of the report in hand
   logic                                  busy_ff, busy_in;
   logic [SLOT_COUNT-1:0]                 pend_ff, pend_in;
   logic [SLOT_COUNT-1:0]                 active_ff, active_in;
   logic [SLOT_COUNT-1:0]                 touch_ff;
   logic [RECORD_COUNT-1:0][RECORD_W-1:0] rec_ff;
   logic [COUNT_W-1:0]                    count_ff;
   logic                                  button_ff;
   logic [STAMP_W-1:0]                    stamp_ff;
   logic                                  special_ff;
   entry_kind_type                        special_kind_ff;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   entry_kind_type          kind_ff, kind_in;
   logic [SLOT_ID_W-1:0]    slot_ff, slot_in;
   logic [GEOM_W-1:0]       width_ff, width_in, height_ff, height_in, x_ff, x_in;
   logic [POS_Y_W-1:0]      y_ff, y_in;
   logic [PRESS_W-1:0]      press_ff, press_in;
   logic [COUNT_W-1:0]      cnt_ff, cnt_in;
   logic                    btn_ff, btn_in, last_ff, last_in;
   logic [STAMP_W-1:0]      ts_ff;

   // load side
   logic                    load;
   logic                    id_match;
   logic [SLOT_COUNT-1:0]   new_touch, new_emit;
   logic [COUNT_W-1:0]      new_count;

   // entry side
   logic                    out_free, emit_go, is_last, done;
   logic [SLOT_COUNT-1:0]   slot_oh, below;
   logic [SLOT_ID_W-1:0]    slot_idx;
   logic [REC_IDX_W-1:0]    rec_idx;
   logic                    found, is_touch;
   logic [RECORD_W-1:0]     rec;
   logic [7:0]              b0, b1, b2, b3, b4;
   logic [19:0]             w_prod, h_prod;
   logic [8:0]              press_sum;
   logic [20:0]             press_rnd;
   logic [10:0]             press_q;

   assign id_match  = in_report.report_id == cfg.expected_id;
   assign new_touch = in_report.touch_flags[TOUCH_BIT0 +: SLOT_COUNT];
   assign new_emit  = new_touch | active_ff;

   always_comb begin
      new_count = '0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         new_count = new_count + COUNT_W'(new_emit[s]);
      end
   end

   // lowest slot still waiting for its entry
   always_comb begin
      slot_oh  = '0;
      slot_idx = '0;
      found    = 1'b0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         if (!found && pend_ff[s]) begin
            slot_oh[s] = 1'b1;
            slot_idx   = SLOT_ID_W'(s);
            found      = 1'b1;
         end
      end
   end

   // the k-th touching slot owns record k
   assign below = slot_oh - SLOT_COUNT'(1);
   always_comb begin
      rec_idx = '0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         rec_idx = rec_idx + REC_IDX_W'(touch_ff[s] & below[s]);
      end
   end

   assign rec      = rec_ff[rec_idx];
   assign b0       = rec[7:0];
   assign b1       = rec[15:8];
   assign b2       = rec[23:16];
   assign b3       = rec[31:24];
   assign b4       = rec[39:32];
   assign is_touch = |(touch_ff & slot_oh);

   assign w_prod    = 20'(b3[3:0]) * 20'(cfg.scale_x);
   assign h_prod    = 20'(b3[7:4]) * 20'(cfg.scale_y);
   assign press_sum = 9'(b4) + 9'(cfg.press_ofs);
   assign press_rnd = 21'(press_sum) * 21'(PRESS_MUL) + PRESS_HALF;
   assign press_q   = press_rnd[PRESS_SHIFT +: 11];

   assign out_free = !rsp_valid_ff || out_ready;
   assign emit_go  = busy_ff && out_free;
   assign is_last  = special_ff || ((pend_ff & ~slot_oh) == '0);
   assign done     = emit_go && is_last;
   assign in_ready = !busy_ff || done;
   assign load     = in_valid && in_ready;

   always_comb begin
      kind_in   = special_kind_ff;
      slot_in   = '0;
      width_in  = '0;
      height_in = '0;
      x_in      = '0;
      y_in      = '0;
      press_in  = '0;
      cnt_in    = '0;
      btn_in    = 1'b0;
      last_in   = is_last;
      if (!special_ff) begin
         kind_in = is_touch ? KIND_TOUCH : KIND_LIFT;
         slot_in = slot_idx;
         cnt_in  = count_ff;
         btn_in  = button_ff;
         if (is_touch) begin
            width_in  = (w_prod > 20'(GEOM_MAX)) ? GEOM_MAX : w_prod[GEOM_W-1:0];
            height_in = (h_prod > 20'(GEOM_MAX)) ? GEOM_MAX : h_prod[GEOM_W-1:0];
            x_in      = {b0[7:4], b1};
            y_in      = cfg.max_y - {4'd0, b0[3:0], b2};
            press_in  = (press_q > 11'(PRESS_MAX)) ? PRESS_MAX : press_q[PRESS_W-1:0];
         end
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      pend_in   = pend_ff;
      active_in = active_ff;
      if (emit_go) begin
         pend_in = pend_ff & ~slot_oh;
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in = 1'b1;
         pend_in = (id_match && (new_emit != '0)) ? new_emit : '0;
         if (id_match) begin
            active_in = new_touch;
         end
      end
   end

   assign rsp_valid_in = emit_go ? 1'b1 : (out_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pend_ff      <= '0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pend_ff      <= pend_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         touch_ff        <= new_touch;
         rec_ff          <= in_report.records;
         count_ff        <= new_count;
         button_ff       <= in_report.touch_flags[CLICK_BIT];
         stamp_ff        <= in_stamp;
         special_ff      <= !id_match || (new_emit == '0);
         special_kind_ff <= id_match ? KIND_NONE : KIND_REJECT;
      end
      if (emit_go) begin
         kind_ff   <= kind_in;
         slot_ff   <= slot_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         press_ff  <= press_in;
         cnt_ff    <= cnt_in;
         btn_ff    <= btn_in;
         ts_ff     <= stamp_ff;
         last_ff   <= last_in;
      end
   end

   assign out_valid    = rsp_valid_ff;
   assign out_kind     = kind_ff;
   assign out_slot     = slot_ff;
   assign out_width    = width_ff;
   assign out_height   = height_ff;
   assign out_x        = x_ff;
   assign out_y        = y_ff;
   assign out_pressure = press_ff;
   assign out_count    = cnt_ff;
   assign out_button   = btn_ff;
   assign out_stamp    = ts_ff;
   assign out_last     = last_ff;

endmodule

`default_nettype wire
